### rtl/core/crf_pkg.sv
// Shared types, constants and the arctangent table of the roll filter.
package crf_pkg;

   localparam int XY_W = 35;
   localparam int ANG_W = 26;
   localparam int STEP_W = 5;
   localparam int NUM_W = 52;
   localparam int REM_W = 27;
   localparam int QUO_W = 25;
   localparam logic [REM_W-1:0] GYRO_DIVISOR = 27'd131000000;
   localparam logic [NUM_W-1:0] GYRO_ROUND = 52'd65500000;
   localparam logic signed [ANG_W-1:0] RIGHT_ANGLE = 26'sd5898240;

   typedef logic signed [XY_W-1:0] xy_type;
   typedef logic signed [ANG_W-1:0] angle_type;

   function automatic angle_type atan_q16(input logic [STEP_W-1:0] idx);
      angle_type r;
      case (idx)
         5'd0: r = 26'sd2949120;
         5'd1: r = 26'sd1740967;
         5'd2: r = 26'sd919879;
         5'd3: r = 26'sd466945;
         5'd4: r = 26'sd234379;
         5'd5: r = 26'sd117304;
         5'd6: r = 26'sd58666;
         5'd7: r = 26'sd29335;
         5'd8: r = 26'sd14668;
         5'd9: r = 26'sd7334;
         5'd10: r = 26'sd3667;
         5'd11: r = 26'sd1833;
         5'd12: r = 26'sd917;
         5'd13: r = 26'sd458;
         5'd14: r = 26'sd229;
         5'd15: r = 26'sd115;
         5'd16: r = 26'sd57;
         5'd17: r = 26'sd29;
         5'd18: r = 26'sd14;
         5'd19: r = 26'sd7;
         5'd20: r = 26'sd4;
         5'd21: r = 26'sd2;
         5'd22: r = 26'sd1;
         default: r = 26'sd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/crf_cordic.sv
// Iterative vectoring CORDIC that turns accelerometer Y and Z into a roll angle.
module crf_cordic #(
   parameter int STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [15:0]     accel_y,
   input  logic signed [15:0]     accel_z,
   output logic                   busy,
   output crf_pkg::angle_type     angle
);
   import crf_pkg::*;

   xy_type x_ff, x_in, y_ff, y_in;
   angle_type ang_ff, ang_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic busy_ff, busy_in, zero_ff, zero_in;
   xy_type ay_w, az_w;

   assign ay_w = {{3{accel_y[15]}}, accel_y, 16'b0};
   assign az_w = {{3{accel_z[15]}}, accel_z, 16'b0};

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      ang_in = ang_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         zero_in = (accel_y == 16'sd0) && (accel_z == 16'sd0);
         if (accel_z < 0) begin
            if (accel_y >= 0) begin
               x_in = ay_w;
               y_in = -az_w;
               ang_in = RIGHT_ANGLE;
            end else begin
               x_in = -ay_w;
               y_in = az_w;
               ang_in = -RIGHT_ANGLE;
            end
         end else begin
            x_in = az_w;
            y_in = ay_w;
            ang_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + (y_ff >>> step_ff);
            y_in = y_ff - (x_ff >>> step_ff);
            ang_in = ang_ff + atan_q16(step_ff);
         end else begin
            x_in = x_ff - (y_ff >>> step_ff);
            y_in = y_ff + (x_ff >>> step_ff);
            ang_in = ang_ff - atan_q16(step_ff);
         end
         step_in = step_ff + 5'd1;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      ang_ff <= ang_in;
      zero_ff <= zero_in;
   end

   assign busy = busy_ff;
   assign angle = zero_ff ? '0 : ang_ff;

endmodule

### rtl/core/crf_serial_div.sv
// Bit-serial restoring divider by the fixed gyro scale, one quotient bit per cycle.
module crf_serial_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [crf_pkg::NUM_W-1:0]      numer,
   output logic                           busy,
   output logic [crf_pkg::QUO_W-1:0]      quot
);
   import crf_pkg::*;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [REM_W:0] trial;

   assign trial = {rem_ff, num_ff[NUM_W-1]};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in = numer;
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, GYRO_DIVISOR}) begin
            rem_in = REM_W'(trial - {1'b0, GYRO_DIVISOR});
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[REM_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quot = num_ff[QUO_W-1:0];

endmodule

### rtl/core/complementary_roll_filter.sv
// Top level of the complementary roll filter.
// A request passes through the states PROD, LOAD, RUN, ADD, MUL and SUM before its
// result: the gyro increment comes from a bit-serial divider that produces one
// quotient bit per cycle, the CORDIC runs in parallel with it, and the ADD, MUL
// and SUM states follow, where SUM waits while an earlier result is not taken. A new
// request is taken while a finished result waits on rsp.
module complementary_roll_filter #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // accel_y, accel_z, gyro_x, elapsed_us, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // lean_angle, max_lean_right, max_lean_left
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);
   import crf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PROD, ST_LOAD, ST_RUN, ST_ADD, ST_MUL, ST_SUM
   } state_type;

   state_type state_ff;
   logic [15:0] weight_ff;
   logic signed [15:0] ay_ff, az_ff, gx_ff;
   logic [19:0] us_ff;
   logic [35:0] prod_ff;
   logic signed [31:0] roll_ff, max_ff, min_ff, s_ff;
   logic signed [48:0] p1_ff, p2_ff;
   logic rsp_valid_ff;
   logic [95:0] rsp_data_ff;

   logic cordic_busy, div_busy;
   angle_type acc_angle;
   logic [QUO_W-1:0] quot;
   logic [15:0] gabs;
   logic [NUM_W-1:0] numer;
   logic signed [33:0] s_sum;
   logic signed [49:0] mix;
   logic signed [33:0] mix_sh;
   logic signed [31:0] roll_in;

   assign gabs = gx_ff[15] ? 16'(-gx_ff) : gx_ff;
   assign numer = {prod_ff, 16'b0} + GYRO_ROUND;
   assign s_sum = 34'(roll_ff) + (gx_ff[15] ? -34'(quot) : 34'(quot));
   assign mix = 50'(p1_ff) + 50'(p2_ff) + 50'sd32768;
   assign mix_sh = 34'(mix >>> 16);
   assign roll_in = (mix_sh > 34'sd2147483647) ? 32'sh7FFFFFFF :
                    (mix_sh < -34'sd2147483648) ? 32'sh80000000 : 32'(mix_sh);

   crf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(state_ff == ST_PROD),
      .accel_y(ay_ff), .accel_z(az_ff), .busy(cordic_busy), .angle(acc_angle)
   );

   crf_serial_div u_div (
      .clock(clock), .reset(reset), .start(state_ff == ST_LOAD),
      .numer(numer), .busy(div_busy), .quot(quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         weight_ff <= 16'd62915;
         roll_ff <= '0;
         max_ff <= '0;
         min_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            weight_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != ST_SUM) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  ay_ff <= req_tdata[15:0];
                  az_ff <= req_tdata[31:16];
                  gx_ff <= req_tdata[47:32];
                  us_ff <= req_tdata[67:48];
                  state_ff <= ST_PROD;
               end
            end
            ST_PROD: begin
               prod_ff <= 36'(gabs) * 36'(us_ff);
               state_ff <= ST_LOAD;
            end
            ST_LOAD: state_ff <= ST_RUN;
            ST_RUN: begin
               if (!cordic_busy && !div_busy) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               s_ff <= (s_sum > 34'sd2147483647) ? 32'sh7FFFFFFF :
                       (s_sum < -34'sd2147483648) ? 32'sh80000000 : 32'(s_sum);
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               p1_ff <= 49'($signed({1'b0, weight_ff})) * 49'(s_ff);
               p2_ff <= 49'(18'sd65536 - $signed({2'b0, weight_ff})) * 49'(acc_angle);
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  roll_ff <= roll_in;
                  max_ff <= (roll_in > max_ff) ? roll_in : max_ff;
                  min_ff <= (roll_in < min_ff) ? roll_in : min_ff;
                  rsp_data_ff <= {((roll_in < min_ff) ? roll_in : min_ff),
                                  ((roll_in > max_ff) ? roll_in : max_ff), roll_in};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
